// ----- rtl/core/duc_pkg.sv -----
// Package for the door unlock controller: widths, command and result codes,
// the classified operation carried from the front end to the executor.
// Depends on nothing; every other file of the block imports it.
package duc_pkg;

   // Width of each unlock countdown (16 to 32 bits).
   localparam int TIMER_BITS = 32;
   localparam int CFG_BITS   = 32;
   localparam int CSR_IDX_BITS = 3;

   localparam int NUM_SRC  = 4;
   localparam int SRC_BITS = 2;
   localparam int unsigned SRC_CARD   = 0;
   localparam int unsigned SRC_EXIT   = 1;
   localparam int unsigned SRC_SNIB   = 2;
   localparam int unsigned SRC_REMOTE = 3;

   // Depth of the queue between the front end and the executor.
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // Input command codes.
   localparam logic [3:0] CMD_TICK         = 4'd0;
   localparam logic [3:0] CMD_DOOR_OPEN    = 4'd1;
   localparam logic [3:0] CMD_DOOR_CLOSE   = 4'd2;
   localparam logic [3:0] CMD_EXIT_PRESS   = 4'd3;
   localparam logic [3:0] CMD_EXIT_LONG    = 4'd4;
   localparam logic [3:0] CMD_EXIT_RELEASE = 4'd5;
   localparam logic [3:0] CMD_SNIB_PRESS   = 4'd6;
   localparam logic [3:0] CMD_BATTERY      = 4'd7;
   localparam logic [3:0] CMD_MAINS        = 4'd8;
   localparam logic [3:0] CMD_WIFI         = 4'd9;
   localparam logic [3:0] CMD_SERVER       = 4'd10;
   localparam logic [3:0] CMD_CARD_SEEN    = 4'd11;
   localparam logic [3:0] CMD_CARD_RESULT  = 4'd12;
   localparam logic [3:0] CMD_REMOTE_SET   = 4'd13;

   // Configuration register indexes.
   localparam logic [CSR_IDX_BITS-1:0] CSR_CARD_TIME       = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_EXIT_TIME       = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SNIB_TIME       = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_REMOTE_TIME     = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_EXIT_HOLD_TIME  = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RELOCK_ON_OPEN  = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LONG_EXIT_SNIBS = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SNIB_ON_BATTERY = 3'd7;

   localparam logic [CFG_BITS-1:0] CARD_TIME_RESET   = 32'd5000;
   localparam logic [CFG_BITS-1:0] EXIT_TIME_RESET   = 32'd5000;
   localparam logic [CFG_BITS-1:0] SNIB_TIME_RESET   = 32'd600000;
   localparam logic [CFG_BITS-1:0] REMOTE_TIME_RESET = 32'd5000;

   // Result codes.
   localparam logic [1:0] LOCK_NONE     = 2'd0;
   localparam logic [1:0] LOCK_UNLOCKED = 2'd1;
   localparam logic [1:0] LOCK_LOCKED   = 2'd2;

   localparam logic [2:0] LED_FAST   = 3'd0;
   localparam logic [2:0] LED_MEDIUM = 3'd1;
   localparam logic [2:0] LED_DIM    = 3'd2;
   localparam logic [2:0] LED_BLINK  = 3'd3;
   localparam logic [2:0] LED_STEADY = 3'd4;

   localparam logic [3:0] EV_NONE           = 4'd0;
   localparam logic [3:0] EV_ONLINE_GRANT   = 4'd1;
   localparam logic [3:0] EV_ONLINE_DENY    = 4'd2;
   localparam logic [3:0] EV_OFFLINE_GRANT  = 4'd3;
   localparam logic [3:0] EV_OFFLINE_DENY   = 4'd4;
   localparam logic [3:0] EV_OPEN           = 4'd5;
   localparam logic [3:0] EV_CLOSED         = 4'd6;
   localparam logic [3:0] EV_EXIT           = 4'd7;
   localparam logic [3:0] EV_EXIT_IGNORED   = 4'd8;
   localparam logic [3:0] EV_SNIB_ON        = 4'd9;
   localparam logic [3:0] EV_SNIB_OFF       = 4'd10;
   localparam logic [3:0] EV_BATTERY        = 4'd11;
   localparam logic [3:0] EV_MAINS          = 4'd12;
   localparam logic [3:0] EV_CARD_SEEN      = 4'd13;

   // Beep codes: grant is 100 ms at 1000 Hz, deny 500 ms at 256 Hz,
   // acknowledge 100 ms at 500 Hz.
   localparam logic [1:0] BEEP_NONE  = 2'd0;
   localparam logic [1:0] BEEP_GRANT = 2'd1;
   localparam logic [1:0] BEEP_DENY  = 2'd2;
   localparam logic [1:0] BEEP_ACK   = 2'd3;

   localparam logic [1:0] AUTH_SRC_NONE    = 2'd0;
   localparam logic [1:0] AUTH_SRC_ONLINE  = 2'd1;
   localparam logic [1:0] AUTH_SRC_OFFLINE = 2'd2;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_TICK,
      OP_DOOR_OPEN,
      OP_DOOR_CLOSE,
      OP_EXIT_PRESS,
      OP_EXIT_LONG,
      OP_EXIT_RELEASE,
      OP_SNIB_PRESS,
      OP_BATTERY,
      OP_MAINS,
      OP_WIFI,
      OP_SERVER,
      OP_CARD_SEEN,
      OP_CARD_RESULT,
      OP_REMOTE_SET
   } op_kind_type;

   typedef enum logic [1:0] {
      VERDICT_ONLINE_GRANT,
      VERDICT_ONLINE_DENY,
      VERDICT_OFFLINE_GRANT,
      VERDICT_OFFLINE_DENY
   } verdict_type;

   typedef struct packed {
      op_kind_type kind;
      logic        level_bit;
      verdict_type verdict;
      logic [7:0]  set_mask;
      logic [6:0]  set_values;
   } op_type;

   typedef struct packed {
      logic       relay_on;
      logic [1:0] lock_event;
      logic [2:0] led_mode;
      logic [3:0] event_code;
      logic [1:0] beep_code;
      logic [3:0] active_bits;
      logic [2:0] enable_bits;
      logic       door_is_open;
      logic       battery_power;
      logic       link_up;
      logic [1:0] auth_source;
   } rsp_type;

   // A reload beyond the countdown range saturates to the largest count.
   function automatic logic [TIMER_BITS-1:0] clamp_time(input logic [CFG_BITS-1:0] t);
      logic [TIMER_BITS-1:0] r;
      r = t[TIMER_BITS-1:0];
      if ((t >> TIMER_BITS) != '0) begin
         r = '1;
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/duc_req_if.sv -----
// Request channel of the door unlock controller: one event item per handshake.
// Depends on duc_pkg.
interface duc_req_if;
   import duc_pkg::*;

   logic       valid;
   logic       ready;
   logic [3:0] cmd;
   logic       level_bit;
   logic       found_online;
   logic [7:0] online_level;
   logic [7:0] offline_level;
   logic [7:0] set_mask;
   logic [6:0] set_values;

   modport source (
      output valid, cmd, level_bit, found_online, online_level, offline_level,
             set_mask, set_values,
      input  ready
   );

   modport sink (
      input  valid, cmd, level_bit, found_online, online_level, offline_level,
             set_mask, set_values,
      output ready
   );
endinterface

// ----- rtl/core/duc_rsp_if.sv -----
// Response channel of the door unlock controller: one status item per event.
// Depends on duc_pkg.
interface duc_rsp_if;
   import duc_pkg::*;

   logic       valid;
   logic       ready;
   logic       relay_on;
   logic [1:0] lock_event;
   logic [2:0] led_mode;
   logic [3:0] event_code;
   logic [1:0] beep_code;
   logic [3:0] active_bits;
   logic [2:0] enable_bits;
   logic       door_is_open;
   logic       battery_power;
   logic       link_up;
   logic [1:0] auth_source;

   modport source (
      output valid, relay_on, lock_event, led_mode, event_code, beep_code,
             active_bits, enable_bits, door_is_open, battery_power, link_up,
             auth_source,
      input  ready
   );

   modport sink (
      input  valid, relay_on, lock_event, led_mode, event_code, beep_code,
             active_bits, enable_bits, door_is_open, battery_power, link_up,
             auth_source,
      output ready
   );
endinterface

// ----- rtl/core/duc_front.sv -----
// Front end of the door unlock controller: accepts event items and classifies
// them into operations for the queue. Depends on duc_pkg and duc_req_if.
module duc_front (
   duc_req_if.sink        req_ch,
   output logic           push_valid,
   input  logic           push_ready,
   output duc_pkg::op_type push_op
);
   import duc_pkg::*;

   op_kind_type kind;
   verdict_type verdict;

   always_comb begin
      unique case (req_ch.cmd)
         CMD_TICK:         kind = OP_TICK;
         CMD_DOOR_OPEN:    kind = OP_DOOR_OPEN;
         CMD_DOOR_CLOSE:   kind = OP_DOOR_CLOSE;
         CMD_EXIT_PRESS:   kind = OP_EXIT_PRESS;
         CMD_EXIT_LONG:    kind = OP_EXIT_LONG;
         CMD_EXIT_RELEASE: kind = OP_EXIT_RELEASE;
         CMD_SNIB_PRESS:   kind = OP_SNIB_PRESS;
         CMD_BATTERY:      kind = OP_BATTERY;
         CMD_MAINS:        kind = OP_MAINS;
         CMD_WIFI:         kind = OP_WIFI;
         CMD_SERVER:       kind = OP_SERVER;
         CMD_CARD_SEEN:    kind = OP_CARD_SEEN;
         CMD_CARD_RESULT:  kind = OP_CARD_RESULT;
         CMD_REMOTE_SET:   kind = OP_REMOTE_SET;
         default:          kind = OP_NOP;
      endcase
   end

   // The server answer takes precedence; the local table is used otherwise.
   always_comb begin
      if (req_ch.found_online) begin
         verdict = (req_ch.online_level != 8'd0) ? VERDICT_ONLINE_GRANT
                                                 : VERDICT_ONLINE_DENY;
      end else begin
         verdict = (req_ch.offline_level != 8'd0) ? VERDICT_OFFLINE_GRANT
                                                  : VERDICT_OFFLINE_DENY;
      end
   end

   assign push_valid         = req_ch.valid;
   assign req_ch.ready       = push_ready;
   assign push_op.kind       = kind;
   assign push_op.level_bit  = req_ch.level_bit;
   assign push_op.verdict    = verdict;
   assign push_op.set_mask   = req_ch.set_mask;
   assign push_op.set_values = req_ch.set_values;

endmodule

// ----- rtl/core/duc_queue.sv -----
// Short operation queue between the front end and the executor.
// Depends on duc_pkg.
module duc_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   output logic            push_ready,
   input  duc_pkg::op_type push_op,
   output logic            pop_valid,
   input  logic            pop_ready,
   output duc_pkg::op_type pop_op
);
   import duc_pkg::*;

   localparam logic [QUEUE_PTR_BITS-1:0] LAST_PTR = QUEUE_PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_CNT_BITS-1:0] FULL_CNT = QUEUE_CNT_BITS'(QUEUE_DEPTH);

   op_type                    entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_op     = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count beyond depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a lone push");
`endif

endmodule

// ----- rtl/core/duc_exec.sv -----
// Executor of the door unlock controller: holds the unlock sources, countdowns,
// flags and configuration, and registers one result item per operation.
// Depends on duc_pkg and duc_rsp_if.
module duc_exec (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              pop_valid,
   output logic                              pop_ready,
   input  duc_pkg::op_type                   pop_op,
   input  logic                              csr_we,
   input  logic [duc_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [duc_pkg::CFG_BITS-1:0]      csr_wdata,
   duc_rsp_if.source                         rsp_ch
);
   import duc_pkg::*;

   // Configuration.
   logic [CFG_BITS-1:0] time_ff [NUM_SRC];
   logic [CFG_BITS-1:0] hold_time_ff;
   logic                relock_on_open_ff, long_exit_snibs_ff, snib_on_battery_ff;

   // Controller state.
   logic [TIMER_BITS-1:0] rem_ff [NUM_SRC];
   logic [TIMER_BITS-1:0] rem_in [NUM_SRC];
   logic [NUM_SRC-1:0]    act_ff, act_in;
   logic [2:0]            en_ff, en_in;
   logic                  door_ff, door_in, batt_ff, batt_in;
   logic                  wifi_ff, wifi_in, srv_ff, srv_in;
   logic [1:0]            auth_ff, auth_in;
   logic                  unlocked_ff, unlocked_in;

   // Output register.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic               fire, snib_ok, link;
   logic [3:0]         ev;
   logic [1:0]         beep, lock_ev;
   logic [2:0]         led;
   logic [NUM_SRC-1:0] src_mask, src_vals;
   logic [2:0]         en_mask;

   assign pop_ready = !rsp_valid_ff || rsp_ch.ready;
   assign fire      = pop_valid && pop_ready;
   assign snib_ok   = en_ff[SRC_SNIB] && (!batt_ff || snib_on_battery_ff);
   assign src_mask  = pop_op.set_mask[6:3];
   assign src_vals  = pop_op.set_values[6:3];
   assign en_mask   = pop_op.set_mask[2:0];

   always_comb begin
      rem_in  = rem_ff;
      act_in  = act_ff;
      en_in   = en_ff;
      door_in = door_ff;
      batt_in = batt_ff;
      wifi_in = wifi_ff;
      srv_in  = srv_ff;
      auth_in = auth_ff;
      ev      = EV_NONE;
      beep    = BEEP_NONE;

      unique case (pop_op.kind)
         OP_TICK: begin
            for (int s = 0; s < NUM_SRC; s++) begin
               if (act_ff[s[SRC_BITS-1:0]]) begin
                  if (rem_ff[s[SRC_BITS-1:0]] == '0) begin
                     act_in[s[SRC_BITS-1:0]] = 1'b0;
                     if (s == SRC_CARD) begin
                        auth_in = AUTH_SRC_NONE;
                     end
                  end else begin
                     rem_in[s[SRC_BITS-1:0]] = rem_ff[s[SRC_BITS-1:0]] - 1'b1;
                  end
               end
            end
         end
         OP_DOOR_OPEN: begin
            if (relock_on_open_ff) begin
               act_in[SRC_EXIT] = 1'b0;
               if (act_ff[SRC_CARD]) begin
                  act_in[SRC_CARD] = 1'b0;
                  auth_in          = AUTH_SRC_NONE;
               end
            end
            door_in = 1'b1;
            ev      = EV_OPEN;
         end
         OP_DOOR_CLOSE: begin
            door_in = 1'b0;
            ev      = EV_CLOSED;
         end
         OP_EXIT_PRESS: begin
            if (en_ff[SRC_EXIT]) begin
               act_in[SRC_EXIT] = 1'b1;
               rem_in[SRC_EXIT] = clamp_time(time_ff[SRC_EXIT]);
               ev               = EV_EXIT;
            end else begin
               ev = EV_EXIT_IGNORED;
            end
         end
         OP_EXIT_LONG: begin
            if (long_exit_snibs_ff) begin
               if (act_ff[SRC_SNIB]) begin
                  beep             = BEEP_ACK;
                  act_in[SRC_SNIB] = 1'b0;
                  act_in[SRC_EXIT] = 1'b0;
                  ev               = EV_SNIB_OFF;
               end else if (snib_ok) begin
                  beep             = BEEP_GRANT;
                  act_in[SRC_SNIB] = 1'b1;
                  rem_in[SRC_SNIB] = clamp_time(time_ff[SRC_SNIB]);
                  act_in[SRC_EXIT] = 1'b0;
                  ev               = EV_SNIB_ON;
               end
            end
         end
         OP_EXIT_RELEASE: begin
            if (act_ff[SRC_EXIT] && (hold_time_ff != '0)) begin
               rem_in[SRC_EXIT] = clamp_time(hold_time_ff);
            end
         end
         OP_SNIB_PRESS: begin
            if (act_ff[SRC_SNIB]) begin
               act_in[SRC_SNIB] = 1'b0;
               ev               = EV_SNIB_OFF;
            end else if (snib_ok) begin
               act_in[SRC_SNIB] = 1'b1;
               rem_in[SRC_SNIB] = clamp_time(time_ff[SRC_SNIB]);
               ev               = EV_SNIB_ON;
            end
         end
         OP_BATTERY: begin
            batt_in = 1'b1;
            ev      = EV_BATTERY;
         end
         OP_MAINS: begin
            batt_in = 1'b0;
            ev      = EV_MAINS;
         end
         OP_WIFI:   wifi_in = pop_op.level_bit;
         OP_SERVER: srv_in  = pop_op.level_bit;
         OP_CARD_SEEN: begin
            beep = BEEP_ACK;
            ev   = EV_CARD_SEEN;
         end
         OP_CARD_RESULT: begin
            if (!en_ff[SRC_CARD]) begin
               beep = BEEP_DENY;
            end else begin
               unique case (pop_op.verdict)
                  VERDICT_ONLINE_GRANT: begin
                     act_in[SRC_CARD] = 1'b1;
                     rem_in[SRC_CARD] = clamp_time(time_ff[SRC_CARD]);
                     auth_in          = AUTH_SRC_ONLINE;
                     beep             = BEEP_GRANT;
                     ev               = EV_ONLINE_GRANT;
                  end
                  VERDICT_OFFLINE_GRANT: begin
                     act_in[SRC_CARD] = 1'b1;
                     rem_in[SRC_CARD] = clamp_time(time_ff[SRC_CARD]);
                     auth_in          = AUTH_SRC_OFFLINE;
                     beep             = BEEP_GRANT;
                     ev               = EV_OFFLINE_GRANT;
                  end
                  VERDICT_ONLINE_DENY: begin
                     beep = BEEP_DENY;
                     ev   = EV_ONLINE_DENY;
                  end
                  default: begin
                     beep = BEEP_DENY;
                     ev   = EV_OFFLINE_DENY;
                  end
               endcase
            end
         end
         OP_REMOTE_SET: begin
            en_in = (en_ff & ~en_mask) | (pop_op.set_values[2:0] & en_mask);
            for (int s = 0; s < NUM_SRC; s++) begin
               if (src_mask[s[SRC_BITS-1:0]]) begin
                  act_in[s[SRC_BITS-1:0]] = src_vals[s[SRC_BITS-1:0]];
                  if (src_vals[s[SRC_BITS-1:0]]) begin
                     rem_in[s[SRC_BITS-1:0]] = clamp_time(time_ff[s[SRC_BITS-1:0]]);
                     if (s == SRC_CARD) begin
                        beep = BEEP_GRANT;
                     end
                  end
               end
            end
            // Snib renewal looks at the snib after the set above.
            if (pop_op.set_mask[7] && act_in[SRC_SNIB]) begin
               rem_in[SRC_SNIB] = clamp_time(time_ff[SRC_SNIB]);
            end
         end
         default: begin
         end
      endcase

      lock_ev     = LOCK_NONE;
      unlocked_in = unlocked_ff;
      if (act_in != '0) begin
         unlocked_in = 1'b1;
         if (!unlocked_ff) begin
            lock_ev = LOCK_UNLOCKED;
         end
      end else if (unlocked_ff) begin
         unlocked_in = 1'b0;
         lock_ev     = LOCK_LOCKED;
      end

      link = wifi_in && srv_in;
      if (act_in[SRC_CARD] || act_in[SRC_EXIT]) begin
         led = LED_FAST;
      end else if (act_in[SRC_SNIB] || act_in[SRC_REMOTE]) begin
         led = LED_MEDIUM;
      end else if (batt_in) begin
         led = LED_DIM;
      end else if (!link) begin
         led = LED_BLINK;
      end else begin
         led = LED_STEADY;
      end

      rsp_in.relay_on      = unlocked_in;
      rsp_in.lock_event    = lock_ev;
      rsp_in.led_mode      = led;
      rsp_in.event_code    = ev;
      rsp_in.beep_code     = beep;
      rsp_in.active_bits   = act_in;
      rsp_in.enable_bits   = en_in;
      rsp_in.door_is_open  = door_in;
      rsp_in.battery_power = batt_in;
      rsp_in.link_up       = link;
      rsp_in.auth_source   = auth_in;

      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff[SRC_CARD]   <= CARD_TIME_RESET;
         time_ff[SRC_EXIT]   <= EXIT_TIME_RESET;
         time_ff[SRC_SNIB]   <= SNIB_TIME_RESET;
         time_ff[SRC_REMOTE] <= REMOTE_TIME_RESET;
         hold_time_ff        <= '0;
         relock_on_open_ff   <= 1'b0;
         long_exit_snibs_ff  <= 1'b1;
         snib_on_battery_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CARD_TIME:       time_ff[SRC_CARD]   <= csr_wdata;
            CSR_EXIT_TIME:       time_ff[SRC_EXIT]   <= csr_wdata;
            CSR_SNIB_TIME:       time_ff[SRC_SNIB]   <= csr_wdata;
            CSR_REMOTE_TIME:     time_ff[SRC_REMOTE] <= csr_wdata;
            CSR_EXIT_HOLD_TIME:  hold_time_ff        <= csr_wdata;
            CSR_RELOCK_ON_OPEN:  relock_on_open_ff   <= csr_wdata[0];
            CSR_LONG_EXIT_SNIBS: long_exit_snibs_ff  <= csr_wdata[0];
            CSR_SNIB_ON_BATTERY: snib_on_battery_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_SRC; s++) begin
            rem_ff[s[SRC_BITS-1:0]] <= '0;
         end
         act_ff       <= '0;
         en_ff        <= '1;
         door_ff      <= 1'b0;
         batt_ff      <= 1'b0;
         wifi_ff      <= 1'b0;
         srv_ff       <= 1'b0;
         auth_ff      <= AUTH_SRC_NONE;
         unlocked_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            rem_ff      <= rem_in;
            act_ff      <= act_in;
            en_ff       <= en_in;
            door_ff     <= door_in;
            batt_ff     <= batt_in;
            wifi_ff     <= wifi_in;
            srv_ff      <= srv_in;
            auth_ff     <= auth_in;
            unlocked_ff <= unlocked_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.relay_on      = rsp_ff.relay_on;
   assign rsp_ch.lock_event    = rsp_ff.lock_event;
   assign rsp_ch.led_mode      = rsp_ff.led_mode;
   assign rsp_ch.event_code    = rsp_ff.event_code;
   assign rsp_ch.beep_code     = rsp_ff.beep_code;
   assign rsp_ch.active_bits   = rsp_ff.active_bits;
   assign rsp_ch.enable_bits   = rsp_ff.enable_bits;
   assign rsp_ch.door_is_open  = rsp_ff.door_is_open;
   assign rsp_ch.battery_power = rsp_ff.battery_power;
   assign rsp_ch.link_up       = rsp_ff.link_up;
   assign rsp_ch.auth_source   = rsp_ff.auth_source;

`ifndef ASSERT_OFF
   a_relay_matches_sources: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.relay_on == (rsp_ff.active_bits != '0)))
      else $error("relay does not follow the unlock sources");

   a_unlock_event_relay: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.lock_event == LOCK_UNLOCKED)) |-> rsp_ff.relay_on)
      else $error("unlock reported with the relay off");

   a_steady_led: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.led_mode == LED_STEADY))
         |-> (rsp_ff.link_up && !rsp_ff.battery_power))
      else $error("steady LED without link or on battery");

   a_state_follows_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> (unlocked_ff == rsp_ff.relay_on))
      else $error("lock state and last result disagree");
`endif

endmodule

// ----- rtl/core/door_unlock_controller.sv -----
// Top level of the door unlock controller: front end, operation queue and
// executor. Depends on duc_pkg, duc_req_if, duc_rsp_if and the core modules.
//
// Usage. Each request item carries one event: a millisecond tick, a door or
// button event, a power or link change, a card sighting, a card lookup result
// or a remote state set. Every accepted item yields exactly one response item
// with the relay, lock transition, LED mode, event and beep codes and the
// status flags as they stand after that event.
// The configuration port writes one register per cycle when csr_we is high;
// it is meant to be written while no item is in flight.
// A response item passes through the queue and then the output register before
// it is valid. The block takes one item per cycle while the receiver keeps
// ready high; the executor updates all four countdowns and the flags together
// for each operation, so its step sets the rate.
// When the receiver stalls, the result waits in the output register and the
// queue of two entries keeps accepting until full, then req_ch.ready falls.
// Reset is synchronous and active high: sources inactive, countdowns zero,
// all sources enabled, flags clear, configuration at its default values.
module door_unlock_controller (
   input  logic                              clock,
   input  logic                              reset,
   duc_req_if.sink                           req_ch,
   duc_rsp_if.source                         rsp_ch,
   input  logic                              csr_we,
   input  logic [duc_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [duc_pkg::CFG_BITS-1:0]      csr_wdata
);
   import duc_pkg::*;

   // Front end to queue.
   logic   push_valid, push_ready;
   op_type push_op;

   // Queue to executor.
   logic   pop_valid, pop_ready;
   op_type pop_op;

   // The front end decodes the command and settles the card verdict.
   duc_front u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op)
   );

   // The queue lets the front end keep taking items while the executor waits.
   duc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_op     (pop_op)
   );

   // The executor owns all controller state and the registered response.
   duc_exec u_exec (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_op    (pop_op),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ----- verif/door_event_checker.sv -----
`timescale 1ns / 1ps
// Checker for the door unlock controller: watches the event and status channels
// and the register port, predicts each status item and compares it field by field.
// Depends on duc_pkg, duc_req_if and duc_rsp_if.
module door_event_checker (
   input  logic                             clock,
   input  logic                             reset,
   duc_req_if                               req_ch,
   duc_rsp_if                               rsp_ch,
   input  logic                             csr_we,
   input  logic [duc_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [duc_pkg::CFG_BITS-1:0]     csr_wdata,
   output int unsigned                      fail_count,
   output int unsigned                      awaiting
);
   import duc_pkg::*;

   // Settings as last written.
   logic [CFG_BITS-1:0] reload_ms [NUM_SRC];
   logic [CFG_BITS-1:0] hold_ms;
   logic                relock_open;
   logic                long_snib;
   logic                snib_batt;

   // Controller state.
   logic [TIMER_BITS-1:0] countdown [NUM_SRC];
   logic [NUM_SRC-1:0]    armed;
   logic [2:0]            enabled;
   logic                  door_ajar;
   logic                  battery_mode;
   logic                  wifi_up;
   logic                  server_up;
   logic [1:0]            auth_from;
   logic                  relay_latched;

   rsp_type pending_status [$];

   task automatic restore_defaults();
      reload_ms[SRC_CARD]   = CARD_TIME_RESET;
      reload_ms[SRC_EXIT]   = EXIT_TIME_RESET;
      reload_ms[SRC_SNIB]   = SNIB_TIME_RESET;
      reload_ms[SRC_REMOTE] = REMOTE_TIME_RESET;
      hold_ms       = '0;
      relock_open   = 1'b0;
      long_snib     = 1'b1;
      snib_batt     = 1'b0;
      for (int s = 0; s < NUM_SRC; s++) countdown[s] = '0;
      armed         = '0;
      enabled       = 3'b111;
      door_ajar     = 1'b0;
      battery_mode  = 1'b0;
      wifi_up       = 1'b0;
      server_up     = 1'b0;
      auth_from     = AUTH_SRC_NONE;
      relay_latched = 1'b0;
   endtask

   task automatic store_reg(input logic [CSR_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] v);
      case (idx)
         CSR_CARD_TIME:       reload_ms[SRC_CARD] = v;
         CSR_EXIT_TIME:       reload_ms[SRC_EXIT] = v;
         CSR_SNIB_TIME:       reload_ms[SRC_SNIB] = v;
         CSR_REMOTE_TIME:     reload_ms[SRC_REMOTE] = v;
         CSR_EXIT_HOLD_TIME:  hold_ms = v;
         CSR_RELOCK_ON_OPEN:  relock_open = v[0];
         CSR_LONG_EXIT_SNIBS: long_snib = v[0];
         CSR_SNIB_ON_BATTERY: snib_batt = v[0];
         default: ;
      endcase
   endtask

   // Reload values beyond the countdown width stick at the top count.
   function automatic logic [TIMER_BITS-1:0] saturate(input logic [CFG_BITS-1:0] t);
      logic [63:0] ceiling;
      ceiling = (64'd1 << TIMER_BITS) - 64'd1;
      if (64'(t) > ceiling) return '1;
      return t[TIMER_BITS-1:0];
   endfunction

   function automatic void arm_source(input int s, input logic [CFG_BITS-1:0] t);
      armed[s]     = 1'b1;
      countdown[s] = saturate(t);
   endfunction

   function automatic logic snib_permitted();
      return enabled[SRC_SNIB] && (!battery_mode || snib_batt);
   endfunction

   function automatic rsp_type apply_event(input logic [3:0] cmd, input logic level,
                                           input logic found, input logic [7:0] on_lvl,
                                           input logic [7:0] off_lvl,
                                           input logic [7:0] set_mask,
                                           input logic [6:0] set_vals);
      rsp_type    r;
      logic [3:0] ev;
      logic [1:0] beep;
      logic [1:0] lock_ev;
      logic       link;
      ev      = EV_NONE;
      beep    = BEEP_NONE;
      lock_ev = LOCK_NONE;
      case (cmd)
         CMD_TICK: begin
            for (int s = 0; s < NUM_SRC; s++) begin
               if (armed[s]) begin
                  if (countdown[s] == '0) begin
                     armed[s] = 1'b0;
                     if (s == SRC_CARD) auth_from = AUTH_SRC_NONE;
                  end else begin
                     countdown[s] = countdown[s] - 1'b1;
                  end
               end
            end
         end
         CMD_DOOR_OPEN: begin
            if (relock_open) begin
               armed[SRC_EXIT] = 1'b0;
               if (armed[SRC_CARD]) begin
                  armed[SRC_CARD] = 1'b0;
                  auth_from = AUTH_SRC_NONE;
               end
            end
            door_ajar = 1'b1;
            ev = EV_OPEN;
         end
         CMD_DOOR_CLOSE: begin
            door_ajar = 1'b0;
            ev = EV_CLOSED;
         end
         CMD_EXIT_PRESS: begin
            if (enabled[SRC_EXIT]) begin
               arm_source(SRC_EXIT, reload_ms[SRC_EXIT]);
               ev = EV_EXIT;
            end else begin
               ev = EV_EXIT_IGNORED;
            end
         end
         CMD_EXIT_LONG: begin
            if (long_snib) begin
               if (armed[SRC_SNIB]) begin
                  beep = BEEP_ACK;
                  armed[SRC_SNIB] = 1'b0;
                  armed[SRC_EXIT] = 1'b0;
                  ev = EV_SNIB_OFF;
               end else if (snib_permitted()) begin
                  beep = BEEP_GRANT;
                  arm_source(SRC_SNIB, reload_ms[SRC_SNIB]);
                  armed[SRC_EXIT] = 1'b0;
                  ev = EV_SNIB_ON;
               end
            end
         end
         CMD_EXIT_RELEASE: begin
            if (armed[SRC_EXIT] && hold_ms != '0) countdown[SRC_EXIT] = saturate(hold_ms);
         end
         CMD_SNIB_PRESS: begin
            if (armed[SRC_SNIB]) begin
               armed[SRC_SNIB] = 1'b0;
               ev = EV_SNIB_OFF;
            end else if (snib_permitted()) begin
               arm_source(SRC_SNIB, reload_ms[SRC_SNIB]);
               ev = EV_SNIB_ON;
            end
         end
         CMD_BATTERY: begin
            battery_mode = 1'b1;
            ev = EV_BATTERY;
         end
         CMD_MAINS: begin
            battery_mode = 1'b0;
            ev = EV_MAINS;
         end
         CMD_WIFI:   wifi_up = level;
         CMD_SERVER: server_up = level;
         CMD_CARD_SEEN: begin
            beep = BEEP_ACK;
            ev = EV_CARD_SEEN;
         end
         CMD_CARD_RESULT: begin
            if (!enabled[SRC_CARD]) begin
               beep = BEEP_DENY;
            end else if (found) begin
               if (on_lvl != 8'd0) begin
                  arm_source(SRC_CARD, reload_ms[SRC_CARD]);
                  auth_from = AUTH_SRC_ONLINE;
                  beep = BEEP_GRANT;
                  ev = EV_ONLINE_GRANT;
               end else begin
                  beep = BEEP_DENY;
                  ev = EV_ONLINE_DENY;
               end
            end else if (off_lvl != 8'd0) begin
               arm_source(SRC_CARD, reload_ms[SRC_CARD]);
               auth_from = AUTH_SRC_OFFLINE;
               beep = BEEP_GRANT;
               ev = EV_OFFLINE_GRANT;
            end else begin
               beep = BEEP_DENY;
               ev = EV_OFFLINE_DENY;
            end
         end
         CMD_REMOTE_SET: begin
            for (int s = 0; s < 3; s++) begin
               if (set_mask[s]) enabled[s] = set_vals[s];
            end
            for (int s = 0; s < NUM_SRC; s++) begin
               if (set_mask[s + 3]) begin
                  if (set_vals[s + 3]) begin
                     arm_source(s, reload_ms[s]);
                     if (s == SRC_CARD) beep = BEEP_GRANT;
                  end else begin
                     armed[s] = 1'b0;
                  end
               end
            end
            if (set_mask[7] && armed[SRC_SNIB]) countdown[SRC_SNIB] = saturate(reload_ms[SRC_SNIB]);
         end
         default: ;
      endcase

      if (armed != '0) begin
         if (!relay_latched) begin
            relay_latched = 1'b1;
            lock_ev = LOCK_UNLOCKED;
         end
      end else if (relay_latched) begin
         relay_latched = 1'b0;
         lock_ev = LOCK_LOCKED;
      end

      link = wifi_up && server_up;
      if (armed[SRC_CARD] || armed[SRC_EXIT])        r.led_mode = LED_FAST;
      else if (armed[SRC_SNIB] || armed[SRC_REMOTE]) r.led_mode = LED_MEDIUM;
      else if (battery_mode)                         r.led_mode = LED_DIM;
      else if (!link)                                r.led_mode = LED_BLINK;
      else                                           r.led_mode = LED_STEADY;

      r.relay_on      = relay_latched;
      r.lock_event    = lock_ev;
      r.event_code    = ev;
      r.beep_code     = beep;
      r.active_bits   = armed;
      r.enable_bits   = enabled;
      r.door_is_open  = door_ajar;
      r.battery_power = battery_mode;
      r.link_up       = link;
      r.auth_source   = auth_from;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         restore_defaults();
         pending_status.delete();
         fail_count = 0;
      end else begin
         if (csr_we) store_reg(csr_index, csr_wdata);
         if (req_ch.valid && req_ch.ready) begin
            pending_status.push_back(apply_event(req_ch.cmd, req_ch.level_bit,
                                                 req_ch.found_online, req_ch.online_level,
                                                 req_ch.offline_level, req_ch.set_mask,
                                                 req_ch.set_values));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_status.size() == 0) begin
               $display("%0t: status item arrived with no event outstanding", $time);
               fail_count++;
            end else begin
               want = pending_status.pop_front();
               check_field("relay_on", want.relay_on, rsp_ch.relay_on);
               check_field("lock_event", want.lock_event, rsp_ch.lock_event);
               check_field("led_mode", want.led_mode, rsp_ch.led_mode);
               check_field("event_code", want.event_code, rsp_ch.event_code);
               check_field("beep_code", want.beep_code, rsp_ch.beep_code);
               check_field("active_bits", want.active_bits, rsp_ch.active_bits);
               check_field("enable_bits", want.enable_bits, rsp_ch.enable_bits);
               check_field("door_is_open", want.door_is_open, rsp_ch.door_is_open);
               check_field("battery_power", want.battery_power, rsp_ch.battery_power);
               check_field("link_up", want.link_up, rsp_ch.link_up);
               check_field("auth_source", want.auth_source, rsp_ch.auth_source);
            end
         end
      end
      awaiting = pending_status.size();
   end

endmodule

// ----- verif/door_unlock_controller_test.sv -----
`timescale 1ns / 1ps
// Top of the door unlock controller testbench: clock, reset, event stimulus,
// register settings and the final verdict. Depends on duc_pkg, the two channel
// interfaces, door_event_checker and the block itself.
module door_unlock_controller_test;
   import duc_pkg::*;

   // Commands the block decodes as nothing at all.
   localparam logic [3:0] CMD_UNUSED_LOW  = 4'd14;
   localparam logic [3:0] CMD_UNUSED_HIGH = 4'd15;

   // Hang guard in nanoseconds: several times the slowest legal run with the
   // longest gaps and stalls.
   localparam longint RUN_LIMIT_NS = 8_000_000;

   logic                    clock;
   logic                    reset;
   logic                    csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [CFG_BITS-1:0]     csr_wdata;
   int unsigned             fail_count;
   int unsigned             awaiting;
   int unsigned             items_sent;
   // While calm is set neither side inserts any idle cycles.
   bit                      calm;

   duc_req_if req_ch ();
   duc_rsp_if rsp_ch ();

   door_unlock_controller u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   door_event_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .awaiting   (awaiting)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Idle lengths: mostly none, often a short one, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Access levels are zero often enough that denials are common.
   function automatic logic [7:0] pick_level();
      if ($urandom_range(0, 99) < 30) return 8'd0;
      return 8'($urandom_range(1, 255));
   endfunction

   // Ticks dominate so that the countdowns actually run out; the unused codes
   // turn up only rarely.
   function automatic logic [3:0] pick_command();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 38) return CMD_TICK;
      if (roll < 42) return CMD_DOOR_OPEN;
      if (roll < 46) return CMD_DOOR_CLOSE;
      if (roll < 52) return CMD_EXIT_PRESS;
      if (roll < 57) return CMD_EXIT_LONG;
      if (roll < 61) return CMD_EXIT_RELEASE;
      if (roll < 66) return CMD_SNIB_PRESS;
      if (roll < 69) return CMD_BATTERY;
      if (roll < 72) return CMD_MAINS;
      if (roll < 76) return CMD_WIFI;
      if (roll < 80) return CMD_SERVER;
      if (roll < 83) return CMD_CARD_SEEN;
      if (roll < 92) return CMD_CARD_RESULT;
      if (roll < 98) return CMD_REMOTE_SET;
      return ($urandom_range(0, 1) != 0) ? CMD_UNUSED_HIGH : CMD_UNUSED_LOW;
   endfunction

   // Presents one event item at a falling edge and holds it until the block
   // takes it. Valid is left high when no gap follows, so that back-to-back
   // items never lower and raise it within the same time step.
   task automatic send_event(input logic [3:0] cmd, input logic level, input logic found,
                             input logic [7:0] on_lvl, input logic [7:0] off_lvl,
                             input logic [7:0] mask, input logic [6:0] vals);
      int unsigned gap;
      @(negedge clock);
      req_ch.valid         <= 1'b1;
      req_ch.cmd           <= cmd;
      req_ch.level_bit     <= level;
      req_ch.found_online  <= found;
      req_ch.online_level  <= on_lvl;
      req_ch.offline_level <= off_lvl;
      req_ch.set_mask      <= mask;
      req_ch.set_values    <= vals;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Every field is random, whether or not the command reads it, so that all
   // bits of all fields are exercised.
   task automatic send_random_fields(input logic [3:0] cmd);
      send_event(cmd, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 pick_level(), pick_level(), 8'($urandom_range(0, 255)),
                 7'($urandom_range(0, 127)));
   endtask

   task automatic send_ticks(input int unsigned count);
      repeat (count) send_random_fields(CMD_TICK);
   endtask

   // Holds the sender back until every outstanding status item has come out,
   // then lets the pipeline settle.
   task automatic wait_for_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (awaiting != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Writes all eight registers on consecutive cycles; the block is idle.
   task automatic load_settings(input logic [CFG_BITS-1:0] card, input logic [CFG_BITS-1:0] ext,
                                input logic [CFG_BITS-1:0] snib, input logic [CFG_BITS-1:0] remote,
                                input logic [CFG_BITS-1:0] hold, input logic [CFG_BITS-1:0] relock,
                                input logic [CFG_BITS-1:0] long_press,
                                input logic [CFG_BITS-1:0] battery_snib);
      logic [CFG_BITS-1:0] values [8];
      logic [CSR_IDX_BITS-1:0] order [8];
      values = '{card, ext, snib, remote, hold, relock, long_press, battery_snib};
      order  = '{CSR_CARD_TIME, CSR_EXIT_TIME, CSR_SNIB_TIME, CSR_REMOTE_TIME,
                 CSR_EXIT_HOLD_TIME, CSR_RELOCK_ON_OPEN, CSR_LONG_EXIT_SNIBS,
                 CSR_SNIB_ON_BATTERY};
      for (int i = 0; i < 8; i++) begin
         @(negedge clock);
         csr_we    <= 1'b1;
         csr_index <= order[i];
         csr_wdata <= values[i];
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Short timers so that expiry, relock and hold behaviour come up often.
   // The single-bit registers get junk in their upper bits, which the block
   // must ignore.
   task automatic load_random_small();
      load_settings($urandom_range(0, 20), $urandom_range(0, 20), $urandom_range(0, 20),
                    $urandom_range(0, 20), $urandom_range(0, 10),
                    {31'($urandom), 1'($urandom_range(0, 1))},
                    {31'($urandom), 1'($urandom_range(0, 1))},
                    {31'($urandom), 1'($urandom_range(0, 1))});
   endtask

   // Mostly well-formed sequences: a card swipe followed by its lookup result,
   // an exit press held over some ticks and released, a door opened and shut,
   // runs of ticks. The rest are single events of any kind.
   task automatic random_scenario();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1: begin
            send_random_fields(CMD_CARD_SEEN);
            send_random_fields(CMD_CARD_RESULT);
         end
         2: begin
            send_random_fields(CMD_EXIT_PRESS);
            send_ticks($urandom_range(0, 6));
            send_random_fields(CMD_EXIT_RELEASE);
         end
         3: begin
            send_random_fields(CMD_DOOR_OPEN);
            send_ticks($urandom_range(0, 4));
            send_random_fields(CMD_DOOR_CLOSE);
         end
         4, 5: send_ticks($urandom_range(1, 12));
         default: send_random_fields(pick_command());
      endcase
      // Now and then the sender waits for the block to empty completely.
      if ($urandom_range(0, 99) < 2) wait_for_results();
   endtask

   task automatic run_phase(input int unsigned count);
      int unsigned target;
      target = items_sent + count;
      while (items_sent < target) random_scenario();
   endtask

   // The receiver drops ready for random stretches after each cycle it is high.
   initial begin
      int unsigned stall_left;
      rsp_ch.ready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   initial begin
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = CSR_CARD_TIME;
      csr_wdata            = '0;
      req_ch.valid         = 1'b0;
      req_ch.cmd           = CMD_TICK;
      req_ch.level_bit     = 1'b0;
      req_ch.found_online  = 1'b0;
      req_ch.online_level  = '0;
      req_ch.offline_level = '0;
      req_ch.set_mask      = '0;
      req_ch.set_values    = '0;
      items_sent           = 0;
      calm                 = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, at the reset settings. The unused codes must leave
      // everything alone and report nothing.
      send_event(CMD_UNUSED_HIGH, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 7'h7F);
      send_event(CMD_UNUSED_LOW, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 7'h00);
      // Link comes up in two steps; neither step reports an event.
      send_event(CMD_WIFI, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 7'h00);
      send_event(CMD_SERVER, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 7'h00);
      send_event(CMD_CARD_SEEN, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 7'h00);
      // The four lookup verdicts, with the level extremes.
      send_event(CMD_CARD_RESULT, 1'b0, 1'b1, 8'hFF, 8'h00, 8'h00, 7'h00);
      send_event(CMD_CARD_RESULT, 1'b0, 1'b1, 8'h00, 8'hFF, 8'h00, 7'h00);
      send_event(CMD_CARD_RESULT, 1'b0, 1'b0, 8'h00, 8'hFF, 8'h00, 7'h00);
      send_event(CMD_CARD_RESULT, 1'b0, 1'b0, 8'hFF, 8'h00, 8'h00, 7'h00);
      send_event(CMD_DOOR_OPEN, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 7'h00);
      send_event(CMD_DOOR_CLOSE, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 7'h00);
      send_event(CMD_EXIT_PRESS, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 7'h00);
      // With no hold time set, the release must not touch the exit countdown.
      send_event(CMD_EXIT_RELEASE, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 7'h00);
      // On battery the snib may not be set, by long press or by snib button.
      send_event(CMD_BATTERY, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 7'h00);
      send_event(CMD_EXIT_LONG, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 7'h00);
      send_event(CMD_SNIB_PRESS, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 7'h00);
      send_event(CMD_MAINS, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 7'h00);
      // Long press sets the snib, then clears it; both drop the exit source.
      send_event(CMD_EXIT_LONG, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 7'h00);
      send_event(CMD_EXIT_LONG, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 7'h00);
      send_event(CMD_SNIB_PRESS, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 7'h00);
      // Remote set: everything on with snib renewal, then everything off.
      send_event(CMD_REMOTE_SET, 1'b0, 1'b0, 8'h00, 8'h00, 8'hFF, 7'h7F);
      send_event(CMD_REMOTE_SET, 1'b0, 1'b0, 8'h00, 8'h00, 8'h7F, 7'h00);
      // A card result with the card source disabled only beeps a denial, and
      // an exit press with exit disabled is reported as ignored.
      send_event(CMD_CARD_RESULT, 1'b0, 1'b1, 8'h05, 8'h05, 8'h00, 7'h00);
      send_event(CMD_EXIT_PRESS, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 7'h00);
      send_event(CMD_REMOTE_SET, 1'b0, 1'b0, 8'h00, 8'h00, 8'h07, 7'h07);

      // Random part under the reset settings.
      run_phase(130);

      // Short timers with relock on open, long press snib and snib on battery.
      wait_for_results();
      load_settings(3, 2, 6, 4, 5, 1, 1, 1);
      run_phase(230);

      // All registers at their lowest, with no idle cycles on either side.
      wait_for_results();
      calm = 1'b1;
      load_settings(0, 0, 0, 0, 0, 0, 0, 0);
      run_phase(180);
      calm = 1'b0;

      wait_for_results();
      load_random_small();
      run_phase(220);

      // All registers at their highest.
      wait_for_results();
      load_settings('1, '1, '1, '1, '1, '1, '1, '1);
      run_phase(150);

      wait_for_results();
      load_random_small();
      run_phase(240);

      // Drain, then keep the clock running before the verdict so that any stray
      // status item would still be caught by the checker.
      wait_for_results();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && awaiting == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("FAIL");
      $finish;
   end

endmodule
